>>> hw/rtl/cmc_pkg.sv
// ----------------------------------------------------------------------------
// cmc_pkg: shared types for the coordinate mode counter
// Record and result beats, the token passed down the cell chain, constants.
// ----------------------------------------------------------------------------
package cmc_pkg;

  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef struct packed {
    logic signed [30:0] rec_latitude;
    logic signed [31:0] rec_longitude;
    logic               last_record;
  } cmc_in_t;

  typedef struct packed {
    logic signed [30:0] mode_latitude;
    logic signed [31:0] mode_longitude;
    logic [15:0]        mode_count;
    logic               overflowed;
  } cmc_out_t;

  // Token travelling one cell per cycle: the record plus what the chain found.
  typedef struct packed {
    logic              vld;
    logic              done;
    logic [CountW-1:0] count;
    cmc_in_t           rec;
  } cmc_tok_t;

endpackage

>>> hw/rtl/cmc_cell.sv
// ----------------------------------------------------------------------------
// cmc_cell: one table entry of the chain
// Holds one key and its count, matches or claims the passing token.
// ----------------------------------------------------------------------------
module cmc_cell #(
  parameter int unsigned IDX_W    = 8,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmc_pkg::cmc_tok_t    tok_i,
  input  logic [IDX_W-1:0]     idx_i,
  output cmc_pkg::cmc_tok_t    tok_o,
  output logic [IDX_W-1:0]     idx_o
);

  logic                        used_q, used_d;
  logic signed [30:0]          key_lat_q;
  logic signed [31:0]          key_lon_q;
  logic [cmc_pkg::CountW-1:0]  cnt_q, cnt_d;
  logic [cmc_pkg::CountW-1:0]  cnt_inc;
  logic                        live, hit, take;
  cmc_pkg::cmc_tok_t           tok_q, tok_d;
  logic                        vld_q;
  logic [IDX_W-1:0]            idx_q, idx_d;

  assign live    = tok_i.vld && !tok_i.done;
  assign hit     = live && used_q && (tok_i.rec.rec_latitude == key_lat_q)
                   && (tok_i.rec.rec_longitude == key_lon_q);
  assign take    = live && !used_q;
  assign cnt_inc = (cnt_q == cmc_pkg::CountMax) ? cnt_q
                                                : cnt_q + cmc_pkg::CountW'(1);

  always_comb begin
    tok_d  = tok_i;
    idx_d  = idx_i;
    cnt_d  = cnt_q;
    used_d = used_q;
    if (hit) begin
      tok_d.done  = 1'b1;
      tok_d.count = cnt_inc;
      idx_d       = IDX_W'(CELL_IDX);
      cnt_d       = cnt_inc;
    end else if (take) begin
      tok_d.done  = 1'b1;
      tok_d.count = cmc_pkg::CountW'(1);
      idx_d       = IDX_W'(CELL_IDX);
      cnt_d       = cmc_pkg::CountW'(1);
      used_d      = 1'b1;
    end
    // the last beat empties every cell it passes
    if (tok_i.vld && tok_i.rec.last_record) begin
      used_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      used_q <= used_d;
      vld_q  <= tok_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    idx_q <= idx_d;
    cnt_q <= cnt_d;
    if (take) begin
      key_lat_q <= tok_i.rec.rec_latitude;
      key_lon_q <= tok_i.rec.rec_longitude;
    end
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = vld_q;
  end

  assign idx_o = idx_q;

endmodule

>>> hw/rtl/cmc_tail.sv
// ----------------------------------------------------------------------------
// cmc_tail: best-entry tracker at the end of the chain
// Keeps the leading key, its count and the overflow flag; emits the result.
// ----------------------------------------------------------------------------
module cmc_tail #(
  parameter int unsigned IDX_W = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmc_pkg::cmc_tok_t    tok_i,
  input  logic [IDX_W-1:0]     idx_i,
  output logic                 result_valid_o,
  output cmc_pkg::cmc_out_t    result_o
);

  logic [cmc_pkg::CountW-1:0]  best_cnt_q, best_cnt_d;
  logic [IDX_W-1:0]            best_idx_q, best_idx_d;
  logic signed [30:0]          best_lat_q, best_lat_d;
  logic signed [31:0]          best_lon_q, best_lon_d;
  logic                        ovf_q, ovf_d;
  logic                        better;
  logic                        out_vld_q, out_vld_d;
  cmc_pkg::cmc_out_t           out_q, out_d;

  assign better = (tok_i.count > best_cnt_q)
                  || ((tok_i.count == best_cnt_q) && (idx_i < best_idx_q));

  always_comb begin
    best_cnt_d = best_cnt_q;
    best_idx_d = best_idx_q;
    best_lat_d = best_lat_q;
    best_lon_d = best_lon_q;
    ovf_d      = ovf_q;
    out_vld_d  = 1'b0;
    out_d      = out_q;
    if (tok_i.vld) begin
      if (!tok_i.done) begin
        ovf_d = 1'b1;
      end else if (better) begin
        best_cnt_d = tok_i.count;
        best_idx_d = idx_i;
        best_lat_d = tok_i.rec.rec_latitude;
        best_lon_d = tok_i.rec.rec_longitude;
      end
      if (tok_i.rec.last_record) begin
        out_vld_d            = 1'b1;
        out_d.mode_latitude  = best_lat_d;
        out_d.mode_longitude = best_lon_d;
        out_d.mode_count     = best_cnt_d;
        out_d.overflowed     = ovf_d;
        // start the next list from scratch
        best_cnt_d = '0;
        best_idx_d = '0;
        ovf_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_cnt_q <= '0;
      best_idx_q <= '0;
      ovf_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      best_cnt_q <= best_cnt_d;
      best_idx_q <= best_idx_d;
      ovf_q      <= ovf_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_lat_q <= best_lat_d;
    best_lon_q <= best_lon_d;
    out_q      <= out_d;
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

endmodule

>>> hw/rtl/coordinate_mode_counter_core.sv
// ----------------------------------------------------------------------------
// coordinate_mode_counter_core: most frequent coordinate pair of a list
// Chain of ENTRIES table cells followed by a best-entry tracker.
// ----------------------------------------------------------------------------
// Usage:
//   A record beat is taken on a rising edge with start_i high and busy_o low.
//   Each record walks down a chain of ENTRIES cells, one cell per cycle. The
//   first cell holding the same pair bumps its count (saturating at 65535);
//   otherwise the first empty cell claims the pair with count 1. A record
//   that finds neither is dropped and sets the overflow flag.
//   A record with last_record set empties each cell behind it as it passes;
//   at the end of the chain the tracker emits the leading pair (ties to the
//   earliest cell), its count and the overflow flag as one result beat.
//   The last record passes each cell's register, then the tracker's, to the
//   result strobe. Throughput: one record per cycle while busy_o is low;
//   records behind always see the table as left by those ahead (same pace).
//   Reset empties all cells and the tracker; busy_o is high for the first
//   cycle after reset and low from then on.
//   result_valid_o is high for exactly one cycle per result; the receiver
//   cannot stall it.
// ----------------------------------------------------------------------------
module coordinate_mode_counter_core #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  cmc_pkg::cmc_in_t     rec_i,
  output logic                 result_valid_o,
  output cmc_pkg::cmc_out_t    result_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  cmc_pkg::cmc_tok_t     tok [ENTRIES+1];
  logic [IDX_W-1:0]      idx [ENTRIES+1];
  logic                  busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;

  always_comb begin
    tok[0].vld   = start_i && !busy_q;
    tok[0].done  = 1'b0;
    tok[0].count = '0;
    tok[0].rec   = rec_i;
  end
  assign idx[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    cmc_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[i]),
      .idx_i  (idx[i]),
      .tok_o  (tok[i+1]),
      .idx_o  (idx[i+1])
    );
  end

  cmc_tail #(
    .IDX_W (IDX_W)
  ) u_tail (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tok_i          (tok[ENTRIES]),
    .idx_i          (idx[ENTRIES]),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

>>> hw/rtl/cmc_checker.sv
// ----------------------------------------------------------------------------
// cmc_checker: port-level checks for the coordinate mode counter
// Result timing against last-record beats, count and busy behavior.
// ----------------------------------------------------------------------------
module cmc_checker #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_o,
  input  cmc_pkg::cmc_in_t     rec_i,
  input  logic                 result_valid_o,
  input  cmc_pkg::cmc_out_t    result_o
);

  logic last_beat;
  assign last_beat = start_i && !busy_o && rec_i.last_record;

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_beat |-> ##(ENTRIES+1) result_valid_o)
    else $error("no result after last record");

  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(last_beat, ENTRIES+1))
    else $error("result without a last record");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.mode_count != 16'd0))
    else $error("result with zero count");

  a_busy_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("busy held");

endmodule

bind coordinate_mode_counter_core cmc_checker #(
  .ENTRIES (ENTRIES)
) u_cmc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .rec_i          (rec_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
